>>> rtl/core/bbpo_pkg.sv
// ----------------------------------------------------------------------------
// bbpo_pkg: shared types and constants of the brick/ball/paddle overlay
// Holds bus addresses, opcode values, colors and the structs passed between
// the latch decoder, brick store, pixel classifier and top level.
// ----------------------------------------------------------------------------
package bbpo_pkg;

    // Opcodes of an input beat
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Latch addresses
    localparam logic [15:0] ADDR_CTRL    = 16'hc001;
    localparam logic [15:0] ADDR_PADDLE  = 16'hc005;
    localparam logic [15:0] ADDR_BALL_X  = 16'hc006;
    localparam logic [15:0] ADDR_BALL_Y  = 16'hc007;

    // Work RAM window e000..e3ff and the snooped offsets
    localparam logic [5:0] RAM_PAGE       = 6'b111000;
    localparam logic [9:0] OFF_FLASH_ROW  = 10'h02b;
    localparam logic [9:0] OFF_FLASH_COL  = 10'h02c;
    localparam logic [9:0] OFF_BRICK_CTRL = 10'h033;
    localparam logic [4:0] OFF_STORE_HI   = 5'b00010;  // offsets 40..5f

    // Screen limits and board offsets
    localparam logic [7:0] SCREEN_X_MAX = 8'd231;
    localparam logic [7:0] SCREEN_Y_MAX = 8'd199;
    localparam logic [8:0] BOARD_X_OFS  = 9'd24;
    localparam logic [8:0] BOARD_Y_OFS  = 9'd13;

    // Paddle heights
    localparam logic [4:0] PADDLE_SHORT = 5'd8;
    localparam logic [4:0] PADDLE_TALL  = 5'd16;

    // Palette indexes
    localparam logic [3:0] COLOR_NONE   = 4'h0;
    localparam logic [3:0] COLOR_EDGE   = 4'hf;
    localparam logic [3:0] COLOR_BANK   = 4'h3;
    localparam logic [3:0] COLOR_HI     = 4'h7;
    localparam logic [3:0] COLOR_LO     = 4'h5;

    localparam int STORE_DEPTH = 32;
    localparam int STORE_AW    = 5;

    // Latched video state
    typedef struct packed {
        logic       color_bank;
        logic [4:0] paddle_height;
        logic       edge_enable;
        logic [7:0] paddle_y;
        logic [7:0] ball_x;
        logic [7:0] ball_y;
        logic [7:0] flash_row;
        logic [7:0] flash_col;
        logic [7:0] brick_control;
    } vid_state_t;

    // Brick store write port
    typedef struct packed {
        logic                en;
        logic [STORE_AW-1:0] index;
        logic [7:0]          data;
    } store_wr_t;

    // Pixel classification ahead of the store read
    typedef struct packed {
        logic       fixed_hit;
        logic       brick_cand;
        logic [2:0] brick_bit;
        logic [3:0] brick_color;
    } pix_class_t;

endpackage

>>> rtl/core/brick_ball_paddle_overlay_video.sv
// ----------------------------------------------------------------------------
// brick_ball_paddle_overlay_video: overlay video of a paddle-and-bricks board
// A pixel query gives its result in the cycle after acceptance, set by the
// registered read of the brick store. It accepts one beat per cycle unless a
// held result stalls the output; write beats give no result. Reset clears
// all latches and the store valid bits at once; there is no clearing pass.
// ----------------------------------------------------------------------------
module brick_ball_paddle_overlay_video
    import bbpo_pkg::*;
#(
    parameter int BRICK_ROWS = 14
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [15:0] bus_address,
    input  logic [7:0]  bus_data,
    input  logic [7:0]  pixel_x,
    input  logic [7:0]  pixel_y,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        overlay_hit,
    output logic [3:0]  color_index
);

    vid_state_t          state;
    store_wr_t           store_wr;
    pix_class_t          pix;
    logic [STORE_AW-1:0] row_index;
    logic [7:0]          row_data;
    logic                in_fire;
    logic                wr_fire;
    logic                query_fire;

    logic       s1_valid_reg;
    logic       s1_valid_next;
    pix_class_t s1_pix_reg;
    logic [3:0] color;

    // Accept while the result stage is free or draining
    assign in_ready   = !s1_valid_reg || out_ready;
    assign in_fire    = in_valid && in_ready;
    assign wr_fire    = in_fire && (opcode == OP_WRITE);
    assign query_fire = in_fire && (opcode == OP_QUERY);

    bbpo_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_valid    (wr_fire),
        .bus_address (bus_address),
        .bus_data    (bus_data),
        .state       (state),
        .store_wr    (store_wr)
    );

    bbpo_pixel #(
        .BRICK_ROWS (BRICK_ROWS)
    ) u_pixel (
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .state     (state),
        .pix       (pix),
        .row_index (row_index)
    );

    bbpo_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (store_wr),
        .rd_en    (query_fire),
        .rd_index (row_index),
        .rd_data  (row_data)
    );

    // Advance the result stage
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
            s1_valid_next = query_fire;
        else if (out_ready)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    // Hold the classification next to the store read data
    always_ff @(posedge clk)
    begin
        if (query_fire)
            s1_pix_reg <= pix;
    end

    // Resolve priority with the fetched brick row
    always_comb
    begin
        if (s1_pix_reg.fixed_hit)
            color = COLOR_EDGE;
        else if (s1_pix_reg.brick_cand && row_data[s1_pix_reg.brick_bit])
            color = s1_pix_reg.brick_color;
        else
            color = COLOR_NONE;
    end

    assign out_valid   = s1_valid_reg;
    assign color_index = color;
    assign overlay_hit = (color != COLOR_NONE);

endmodule

>>> rtl/core/bbpo_regs.sv
// ----------------------------------------------------------------------------
// bbpo_regs: bus write decoder and video latches
// Decodes CPU write beats into the c001/c005/c006/c007 latches, the snooped
// work RAM control bytes and the brick store write port.
// ----------------------------------------------------------------------------
module bbpo_regs
    import bbpo_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_valid,
    input  logic [15:0] bus_address,
    input  logic [7:0]  bus_data,
    output vid_state_t  state,
    output store_wr_t   store_wr
);

    vid_state_t state_reg;
    vid_state_t state_next;
    logic       ram_hit;
    logic [9:0] ram_off;

    assign ram_hit = (bus_address[15:10] == RAM_PAGE);
    assign ram_off = bus_address[9:0];

    // Decode the write beat into the next latch values
    always_comb
    begin
        state_next = state_reg;
        if (wr_valid)
        begin
            if (bus_address == ADDR_CTRL)
            begin
                state_next.color_bank    = bus_data[6];
                state_next.paddle_height = bus_data[4] ? PADDLE_SHORT : PADDLE_TALL;
                state_next.edge_enable   = ~bus_data[3];
            end
            else if (bus_address == ADDR_PADDLE)
                state_next.paddle_y = bus_data;
            else if (bus_address == ADDR_BALL_X)
                state_next.ball_x = bus_data;
            else if (bus_address == ADDR_BALL_Y)
                state_next.ball_y = bus_data;
            else if (ram_hit && ram_off == OFF_FLASH_ROW)
                state_next.flash_row = bus_data;
            else if (ram_hit && ram_off == OFF_FLASH_COL)
                state_next.flash_col = bus_data;
            else if (ram_hit && ram_off == OFF_BRICK_CTRL)
                state_next.brick_control = bus_data;
        end
    end

    // Route brick bytes to the store
    always_comb
    begin
        store_wr.en    = wr_valid && ram_hit && (ram_off[9:5] == OFF_STORE_HI);
        store_wr.index = ram_off[STORE_AW-1:0];
        store_wr.data  = bus_data;
    end

    // Hold the latches
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else
            state_reg <= state_next;
    end

    assign state = state_reg;

endmodule

>>> rtl/core/bbpo_store.sv
// ----------------------------------------------------------------------------
// bbpo_store: brick row store
// 32 x 8 synchronous memory with one write and one registered read port.
// Per-entry valid bits make unwritten rows read as zero right after reset.
// ----------------------------------------------------------------------------
module bbpo_store
    import bbpo_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  store_wr_t           wr,
    input  logic                rd_en,
    input  logic [STORE_AW-1:0] rd_index,
    output logic [7:0]          rd_data
);

    logic [7:0]             mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] valid_reg;
    logic [7:0]             rd_data_reg;

    // Write the array
    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem[wr.index] <= wr.data;
    end

    // Mark written entries
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (wr.en)
            valid_reg[wr.index] <= 1'b1;
    end

    // Register the read, masking never-written rows to zero
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= valid_reg[rd_index] ? mem[rd_index] : 8'h00;
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/bbpo_pixel.sv
// ----------------------------------------------------------------------------
// bbpo_pixel: pixel classifier
// Maps a screen pixel to board space, tests paddle, edges and ball, and
// prepares the brick cell test and the store row index for the read.
// ----------------------------------------------------------------------------
module bbpo_pixel
    import bbpo_pkg::*;
#(
    parameter int BRICK_ROWS = 14
)
(
    input  logic [7:0]          pixel_x,
    input  logic [7:0]          pixel_y,
    input  vid_state_t          state,
    output pix_class_t          pix,
    output logic [STORE_AW-1:0] row_index
);

    localparam logic [8:0] ROW_SPAN = 9'(BRICK_ROWS * 16);

    logic       on_screen;
    logic [8:0] bx;
    logic [8:0] by;
    logic [9:0] bx_ball;
    logic [8:0] dx;
    logic [8:0] dy;
    logic [3:0] row;
    logic [2:0] bit_sel;
    logic       in_lane;
    logic       bat_hit;
    logic       edge_hit;
    logic       ball_hit;
    logic       brick_area;
    logic       blink_out;

    assign on_screen = (pixel_x <= SCREEN_X_MAX) && (pixel_y <= SCREEN_Y_MAX);
    assign bx        = {1'b0, pixel_x} + BOARD_X_OFS;
    assign by        = {1'b0, pixel_y} + BOARD_Y_OFS;
    assign bx_ball   = {1'b0, bx} + 10'd10;
    assign in_lane   = (bx >= 9'd38) && (bx <= 9'd41);

    // Paddle, edges and ball
    assign bat_hit = state.edge_enable && in_lane
                  && (by >= {1'b0, state.paddle_y})
                  && (by < ({1'b0, state.paddle_y} + {4'b0, state.paddle_height}));

    assign edge_hit = ((bx < 9'd216) && (by >= 9'd16) && (by <= 9'd19))
                   || ((bx >= 9'd216) && (bx <= 9'd221) && (by >= 9'd16) && (by <= 9'd241))
                   || ((bx < 9'd216) && (by >= 9'd238) && (by <= 9'd241))
                   || (!state.edge_enable && in_lane && (by >= 9'd16) && (by <= 9'd241));

    assign ball_hit = (bx_ball >= {2'b0, state.ball_x})
                   && (bx_ball < ({2'b0, state.ball_x} + 10'd3))
                   && (by >= {1'b0, state.ball_y})
                   && (by < ({1'b0, state.ball_y} + 9'd3));

    // Brick cell position and gaps
    assign dx      = bx - 9'd152;
    assign dy      = by - 9'd16;
    assign bit_sel = dx[4:2];
    assign row     = dy[7:4];

    assign brick_area = (bx >= 9'd152) && (bx <= 9'd183)
                     && (by >= 9'd16) && (dy < ROW_SPAN)
                     && (dx[1:0] != 2'b11) && (dy[3:0] != 4'hf);

    assign blink_out = (state.brick_control[1:0] == 2'b11)
                    && (state.flash_col == {5'b0, bit_sel})
                    && (state.flash_row == {4'b0, row});

    // Bank select picks the upper half of the store
    assign row_index = {state.brick_control[4], row};

    always_comb
    begin
        pix.fixed_hit  = on_screen && (bat_hit || edge_hit || ball_hit);
        pix.brick_cand = on_screen && brick_area && !blink_out;
        pix.brick_bit  = bit_sel;
        if (state.color_bank)
            pix.brick_color = COLOR_BANK;
        else if (bit_sel[2])
            pix.brick_color = COLOR_HI;
        else
            pix.brick_color = COLOR_LO;
    end

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the brick/ball/paddle overlay video block
// Drives a stream of CPU write beats and pixel query beats, keeps its own copy
// of the latches and the brick store, and checks every query result in order.
// A short directed table comes first, then three phases of random beats with
// changing idle rates on both sides and one long output stall.
// ----------------------------------------------------------------------------
module tb_top
    import bbpo_pkg::*;
();

    localparam int BRICK_ROWS  = 14;
    localparam int RAND_ITEMS  = 475;      // random beats per phase
    localparam int HOLD_CYCLES = 300;      // long output stall
    localparam int DRAIN_TAIL  = 8;
    localparam int CYCLE_LIMIT = 200000;

    // Row kinds of the directed table
    localparam logic CHK_MODEL = 1'b0;
    localparam logic CHK_TYPED = 1'b1;

    typedef struct {
        logic        op;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [7:0]  px;
        logic [7:0]  py;
        logic        check;
        logic        exp_hit;
        logic [3:0]  exp_color;
    } beat_t;

    typedef struct {
        logic       hit;
        logic [3:0] color;
    } overlay_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        opcode = OP_WRITE;
    logic [15:0] bus_address = '0;
    logic [7:0]  bus_data = '0;
    logic [7:0]  pixel_x = '0;
    logic [7:0]  pixel_y = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        overlay_hit;
    logic [3:0]  color_index;

    // Expectation carried along with the beat on the input side
    logic        beat_check = CHK_MODEL;
    logic        beat_exp_hit = 1'b0;
    logic [3:0]  beat_exp_color = COLOR_NONE;

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          hold_req = 1'b0;
    logic        stall_hold = 1'b0;
    int          cycle_cnt = 0;
    int          fail_cnt = 0;

    overlay_t    pending_overlays[$];

    // Shadow of the block state
    logic [7:0]  brick_mem [32] = '{default: '0};
    logic [7:0]  flash_row_q = '0;
    logic [7:0]  flash_col_q = '0;
    logic [7:0]  brick_ctrl_q = '0;
    logic        color_bank_q = 1'b0;
    logic [4:0]  paddle_h_q = '0;
    logic        edge_en_q = 1'b0;
    logic [7:0]  paddle_y_q = '0;
    logic [7:0]  ball_x_q = '0;
    logic [7:0]  ball_y_q = '0;

    // Directed table: extremes, each object, blink, unmapped writes
    beat_t directed_beats [27] = '{
        '{OP_QUERY, 16'h0000, 8'h00, 8'd0,   8'd0,   CHK_TYPED, 1'b0, COLOR_NONE},
        '{OP_QUERY, 16'h0000, 8'h00, 8'd0,   8'd3,   CHK_TYPED, 1'b1, COLOR_EDGE},
        '{OP_QUERY, 16'h0000, 8'h00, 8'd231, 8'd199, CHK_TYPED, 1'b0, COLOR_NONE},
        '{OP_QUERY, 16'h0000, 8'h00, 8'd232, 8'd0,   CHK_TYPED, 1'b0, COLOR_NONE},
        '{OP_QUERY, 16'hffff, 8'hff, 8'd255, 8'd255, CHK_TYPED, 1'b0, COLOR_NONE},
        '{OP_QUERY, 16'h0000, 8'h00, 8'd14,  8'd50,  CHK_TYPED, 1'b1, COLOR_EDGE},
        '{OP_QUERY, 16'h0000, 8'h00, 8'd192, 8'd100, CHK_TYPED, 1'b1, COLOR_EDGE},
        '{OP_WRITE, ADDR_CTRL,   8'h00, 8'hff, 8'hff, CHK_MODEL, 1'b0, COLOR_NONE},
        '{OP_WRITE, ADDR_PADDLE, 8'd100, 8'hff, 8'hff, CHK_MODEL, 1'b0, COLOR_NONE},
        '{OP_QUERY, 16'h0000, 8'h00, 8'd14,  8'd87,  CHK_TYPED, 1'b1, COLOR_EDGE},
        '{OP_QUERY, 16'h0000, 8'h00, 8'd14,  8'd103, CHK_TYPED, 1'b0, COLOR_NONE},
        '{OP_WRITE, ADDR_CTRL,   8'h50, 8'h00, 8'h00, CHK_MODEL, 1'b0, COLOR_NONE},
        '{OP_WRITE, 16'he040,    8'hff, 8'h00, 8'h00, CHK_MODEL, 1'b0, COLOR_NONE},
        '{OP_QUERY, 16'h0000, 8'h00, 8'd128, 8'd7,   CHK_TYPED, 1'b1, COLOR_BANK},
        '{OP_WRITE, ADDR_CTRL,   8'h18, 8'h00, 8'h00, CHK_MODEL, 1'b0, COLOR_NONE},
        '{OP_QUERY, 16'h0000, 8'h00, 8'd144, 8'd7,   CHK_TYPED, 1'b1, COLOR_HI},
        '{OP_QUERY, 16'h0000, 8'h00, 8'd131, 8'd7,   CHK_TYPED, 1'b0, COLOR_NONE},
        '{OP_WRITE, 16'he033,    8'h03, 8'h00, 8'h00, CHK_MODEL, 1'b0, COLOR_NONE},
        '{OP_QUERY, 16'h0000, 8'h00, 8'd128, 8'd7,   CHK_TYPED, 1'b0, COLOR_NONE},
        '{OP_WRITE, 16'he02c,    8'h05, 8'h00, 8'h00, CHK_MODEL, 1'b0, COLOR_NONE},
        '{OP_QUERY, 16'h0000, 8'h00, 8'd128, 8'd7,   CHK_TYPED, 1'b1, COLOR_LO},
        '{OP_WRITE, 16'hc000,    8'hff, 8'h00, 8'h00, CHK_MODEL, 1'b0, COLOR_NONE},
        '{OP_WRITE, 16'he3ff,    8'hff, 8'h00, 8'h00, CHK_MODEL, 1'b0, COLOR_NONE},
        '{OP_QUERY, 16'hc001, 8'hff, 8'd128, 8'd7,   CHK_MODEL, 1'b0, COLOR_NONE},
        '{OP_WRITE, ADDR_BALL_X, 8'd50, 8'h00, 8'h00, CHK_MODEL, 1'b0, COLOR_NONE},
        '{OP_WRITE, ADDR_BALL_Y, 8'd60, 8'h00, 8'h00, CHK_MODEL, 1'b0, COLOR_NONE},
        '{OP_QUERY, 16'h0000, 8'h00, 8'd18,  8'd48,  CHK_MODEL, 1'b0, COLOR_NONE}
    };

    brick_ball_paddle_overlay_video #(
        .BRICK_ROWS(BRICK_ROWS)
    ) u_top (
        .*
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic bit in_rect(int x, int y, int x0, int y0, int w, int h);
        return x >= x0 && x < x0 + w && y >= y0 && y < y0 + h;
    endfunction

    // Apply one beat to the shadow state; return 1 with the color for a query
    function automatic bit overlay_step(logic op, logic [15:0] addr, logic [7:0] data,
                                        logic [7:0] px, logic [7:0] py,
                                        output logic [3:0] color);
        int         bx;
        int         by;
        int         dx;
        int         dy;
        int         row;
        logic [2:0] col;
        logic [7:0] cells;
        color = COLOR_NONE;
        if (op == OP_WRITE)
        begin
            if (addr == ADDR_CTRL)
            begin
                color_bank_q = data[6];
                paddle_h_q   = data[4] ? PADDLE_SHORT : PADDLE_TALL;
                edge_en_q    = !data[3];
            end
            else if (addr == ADDR_PADDLE)
                paddle_y_q = data;
            else if (addr == ADDR_BALL_X)
                ball_x_q = data;
            else if (addr == ADDR_BALL_Y)
                ball_y_q = data;
            else if (addr[15:10] == RAM_PAGE)
            begin
                if (addr[9:0] == OFF_FLASH_ROW)
                    flash_row_q = data;
                else if (addr[9:0] == OFF_FLASH_COL)
                    flash_col_q = data;
                else if (addr[9:0] == OFF_BRICK_CTRL)
                    brick_ctrl_q = data;
                else if (addr[9:5] == OFF_STORE_HI)
                    brick_mem[addr[4:0]] = data;
            end
            return 1'b0;
        end
        if (px > SCREEN_X_MAX || py > SCREEN_Y_MAX)
            return 1'b1;
        bx = int'(px) + int'(BOARD_X_OFS);
        by = int'(py) + int'(BOARD_Y_OFS);
        // Paddle, then the frame, then the center line, then the ball
        if (edge_en_q && in_rect(bx, by, 38, int'(paddle_y_q), 4, int'(paddle_h_q)))
            color = COLOR_EDGE;
        else if (in_rect(bx, by, 0, 16, 216, 4) || in_rect(bx, by, 216, 16, 6, 226) ||
                 in_rect(bx, by, 0, 238, 216, 4))
            color = COLOR_EDGE;
        else if (!edge_en_q && in_rect(bx, by, 38, 16, 4, 226))
            color = COLOR_EDGE;
        else if (in_rect(bx, by, int'(ball_x_q) - 10, int'(ball_y_q), 3, 3))
            color = COLOR_EDGE;
        else
        begin
            // Bricks: 3x15 cells with a one-pixel gap, one row per store byte
            dx = bx - 152;
            dy = by - 16;
            if (dx < 0 || dx > 31 || dy < 0 || dy >= BRICK_ROWS * 16)
                return 1'b1;
            if (dx % 4 == 3 || dy % 16 == 15)
                return 1'b1;
            col   = 3'(dx / 4);
            row   = dy / 16;
            cells = brick_mem[(int'(brick_ctrl_q & 8'h10) + row) % STORE_DEPTH];
            if (!cells[col])
                return 1'b1;
            if (brick_ctrl_q[1:0] == 2'b11 && flash_col_q == 8'(col) &&
                flash_row_q == 8'(row))
                return 1'b1;
            if (color_bank_q)
                color = COLOR_BANK;
            else
                color = col[2] ? COLOR_HI : COLOR_LO;
        end
        return 1'b1;
    endfunction

    // Offer one beat, after random idle cycles, and hold it until accepted
    task automatic send_beat(beat_t b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        opcode         <= b.op;
        bus_address    <= b.addr;
        bus_data       <= b.data;
        pixel_x        <= b.px;
        pixel_y        <= b.py;
        beat_check     <= b.check;
        beat_exp_hit   <= b.exp_hit;
        beat_exp_color <= b.exp_color;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Track accepted beats and check each result beat against the oldest entry
    always @(posedge clk)
    begin : scoreboard
        logic [3:0] pred_color;
        overlay_t   want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                if (overlay_step(opcode, bus_address, bus_data, pixel_x, pixel_y,
                                 pred_color))
                begin
                    if (beat_check == CHK_TYPED)
                        pending_overlays.push_back('{beat_exp_hit, beat_exp_color});
                    else
                        pending_overlays.push_back('{pred_color != COLOR_NONE,
                                                     pred_color});
                end
            end
            if (out_valid && out_ready)
            begin
                if (pending_overlays.size() == 0)
                begin
                    $error("unexpected result beat: overlay_hit %0d color_index %0d",
                           overlay_hit, color_index);
                    fail_cnt++;
                end
                else
                begin
                    want = pending_overlays.pop_front();
                    if (overlay_hit !== want.hit)
                    begin
                        $error("overlay_hit: expected %0d, actual %0d",
                               want.hit, overlay_hit);
                        fail_cnt++;
                    end
                    if (color_index !== want.color)
                    begin
                        $error("color_index: expected %0d, actual %0d",
                               want.color, color_index);
                        fail_cnt++;
                    end
                end
            end
        end
    end

    // Receiver: random idle cycles, plus the long stall when requested
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !stall_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // Hold the output off long enough for the block to back up its input
    initial
    begin
        wait (hold_req);
        @(posedge clk);
        stall_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        stall_hold <= 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        int    send_pct_by_phase [3] = '{8, 70, 0};
        int    recv_pct_by_phase [3] = '{70, 8, 0};
        beat_t b;
        int    pick;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = send_pct_by_phase[0];
        recv_idle_pct <= recv_pct_by_phase[0];
        foreach (directed_beats[i])
            send_beat(directed_beats[i]);

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = send_pct_by_phase[phase];
            recv_idle_pct <= recv_pct_by_phase[phase];
            if (phase == 2)
                hold_req = 1'b1;
            repeat (RAND_ITEMS)
            begin
                // Fill the unused fields with noise too
                b.addr      = 16'($urandom);
                b.data      = 8'($urandom);
                b.px        = 8'($urandom);
                b.py        = 8'($urandom);
                b.check     = CHK_MODEL;
                b.exp_hit   = 1'b0;
                b.exp_color = COLOR_NONE;
                b.op        = ($urandom_range(99) < 35) ? OP_WRITE : OP_QUERY;
                pick        = $urandom_range(15);
                if (b.op == OP_WRITE)
                begin
                    case (pick)
                        0:  b.addr = ADDR_CTRL;
                        1:  b.addr = ADDR_PADDLE;
                        2:  b.addr = ADDR_BALL_X;
                        3:  b.addr = ADDR_BALL_Y;
                        4:
                        begin
                            b.addr = {RAM_PAGE, OFF_FLASH_ROW};
                            if ($urandom_range(3) != 0)
                                b.data = 8'($urandom_range(15));
                        end
                        5:
                        begin
                            b.addr = {RAM_PAGE, OFF_FLASH_COL};
                            if ($urandom_range(3) != 0)
                                b.data = 8'($urandom_range(9));
                        end
                        6:
                        begin
                            b.addr = {RAM_PAGE, OFF_BRICK_CTRL};
                            if ($urandom_range(1) != 0)
                                b.data[1:0] = 2'b11;
                        end
                        12: ;  // fully random address
                        13: b.addr = {RAM_PAGE, 10'($urandom)};
                        14: b.addr = {ADDR_CTRL[15:3], 3'($urandom)};
                        default: b.addr = {RAM_PAGE, OFF_STORE_HI, 5'($urandom)};
                    endcase
                end
                else
                begin
                    // Aim most queries at the objects
                    case (pick % 10)
                        0, 1: ;  // anywhere, off-screen included
                        2, 3, 4:
                        begin
                            b.px = 8'(128 + $urandom_range(31));
                            b.py = 8'($urandom_range(199));
                        end
                        5, 6:
                        begin
                            b.px = 8'(12 + $urandom_range(5));
                            b.py = 8'($urandom_range(199));
                        end
                        7:
                        begin
                            b.px = ball_x_q - 8'd35 + 8'($urandom_range(4));
                            b.py = ball_y_q - 8'd14 + 8'($urandom_range(4));
                        end
                        8:
                        begin
                            b.px = 8'(188 + $urandom_range(12));
                            b.py = ($urandom_range(1) != 0) ? 8'($urandom_range(8))
                                                            : 8'($urandom_range(199));
                        end
                        default:
                        begin
                            b.px = 8'($urandom_range(231));
                            b.py = 8'($urandom_range(199));
                        end
                    endcase
                end
                send_beat(b);
            end
        end
        in_valid <= 1'b0;

        // Drain the outstanding results, then let the pipeline settle
        while (pending_overlays.size() != 0)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);
        @(negedge clk);
        if (fail_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
